// ----- rtl/tccw_pkg.sv -----
// Shared types and constants for the text console character writer.
// Used by every module under rtl; depends on nothing else.
`default_nettype none

package tccw_pkg;

   // Screen geometry
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;

   // Field widths
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int ADDR_W = 11;
   localparam int CELL_W = CHAR_W + ATTR_W;
   localparam int POS_W  = ROW_W + COL_W + 1;

   // Last row and column of the screen
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

   // Number of distinct linear positions once reduced to the address width
   localparam int POS_LIMIT = (COLUMNS * ROWS > (1 << ADDR_W)) ? (1 << ADDR_W)
                                                              : COLUMNS * ROWS;

   // Character codes
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE  = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_SPACE      = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PRINT_LAST = 8'h7F;

   // Attribute after reset: light grey on black
   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

   // One item waiting in the input register
   typedef struct packed {
      logic              valid;
      logic [CHAR_W-1:0] char_code;
   } in_item_type;

   // One result item
   typedef struct packed {
      logic              cell_write;
      logic [ADDR_W-1:0] cell_address;
      logic [CELL_W-1:0] cell_value;
      logic [ADDR_W-1:0] cursor_position;
   } result_type;

   // Linear cell index, row * COLUMNS + column, reduced to the address width
   function automatic logic [ADDR_W-1:0] linear_pos(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
      logic [POS_W-1:0] full;
      full = POS_W'(row) * POS_W'(COLUMNS) + POS_W'(col);
      return full[ADDR_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/tccw_in_reg.sv -----
// Input register of the text console character writer.
// Holds one accepted character until the result register can take it; uses tccw_pkg.
`default_nettype none

module tccw_in_reg (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic [tccw_pkg::CHAR_W-1:0] req_char_code,
   output logic                             req_stall,
   input  wire logic                        out_free,
   output tccw_pkg::in_item_type            item,
   output logic                             advance
);

   logic                        valid_ff;
   logic                        valid_in;
   logic [tccw_pkg::CHAR_W-1:0] char_ff;
   logic                        take;

   // The held item moves on whenever the result register is free.
   assign advance   = valid_ff && out_free;
   assign take      = req_valid && !req_stall;
   assign req_stall = valid_ff && !out_free;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (take) begin
         char_ff <= req_char_code;
      end
   end

   assign item.valid     = valid_ff;
   assign item.char_code = char_ff;

endmodule

`default_nettype wire

// ----- rtl/tccw_cursor.sv -----
// Cursor state and per-character update of the text console character writer.
// Decodes one character, moves the cursor and forms the result; uses tccw_pkg.
`default_nettype none

module tccw_cursor (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire tccw_pkg::in_item_type       item,
   input  wire logic                        advance,
   input  wire logic [tccw_pkg::ATTR_W-1:0] attribute,
   output tccw_pkg::result_type             result
);

   logic [tccw_pkg::ROW_W-1:0] row_ff;
   logic [tccw_pkg::ROW_W-1:0] row_in;
   logic [tccw_pkg::COL_W-1:0] col_ff;
   logic [tccw_pkg::COL_W-1:0] col_in;
   logic [tccw_pkg::ROW_W-1:0] row_next;
   logic [tccw_pkg::ROW_W-1:0] cell_row;
   logic [tccw_pkg::COL_W-1:0] cell_col;
   logic [tccw_pkg::CHAR_W-1:0] cell_char;
   logic                        is_print;
   logic                        wr;

   // Next row with wrap to the top; there is no scrolling.
   assign row_next = (row_ff == tccw_pkg::ROW_LAST) ? '0 : row_ff + 1'b1;

   // Printable range is a space up to the last 7-bit code.
   assign is_print = (item.char_code >= tccw_pkg::CHAR_SPACE) &&
                     (item.char_code <= tccw_pkg::CHAR_PRINT_LAST);

   // Character decode and cursor movement
   always_comb begin
      row_in    = row_ff;
      col_in    = col_ff;
      cell_row  = row_ff;
      cell_col  = col_ff;
      cell_char = item.char_code;
      wr        = 1'b0;
      if (item.char_code == tccw_pkg::CHAR_NEWLINE) begin
         col_in = '0;
         row_in = row_next;
      end else if (item.char_code == tccw_pkg::CHAR_BACKSPACE) begin
         // Step back one cell, to the previous row's end, or stay at the corner.
         if (col_ff != '0) begin
            col_in = col_ff - 1'b1;
         end else if (row_ff != '0) begin
            row_in = row_ff - 1'b1;
            col_in = tccw_pkg::COL_LAST;
         end
         cell_row  = row_in;
         cell_col  = col_in;
         cell_char = tccw_pkg::CHAR_SPACE;
         wr        = 1'b1;
      end else if (is_print) begin
         wr = 1'b1;
         if (col_ff == tccw_pkg::COL_LAST) begin
            col_in = '0;
            row_in = row_next;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // Cursor moves only when the item passes into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (advance) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // Result fields; a step without a cell write gives zero address and value.
   always_comb begin
      result.cell_write      = wr;
      result.cell_address    = wr ? tccw_pkg::linear_pos(cell_row, cell_col) : '0;
      result.cell_value      = wr ? {attribute, cell_char} : '0;
      result.cursor_position = tccw_pkg::linear_pos(row_in, col_in);
   end

endmodule

`default_nettype wire

// ----- rtl/tccw_out_reg.sv -----
// Result register of the text console character writer.
// Holds one result item until the receiver takes it; uses tccw_pkg.
`default_nettype none

module tccw_out_reg (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  wire tccw_pkg::result_type          result,
   output logic                               out_free,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_cell_write,
   output logic [tccw_pkg::ADDR_W-1:0]        rsp_cell_address,
   output logic [tccw_pkg::CELL_W-1:0]        rsp_cell_value,
   output logic [tccw_pkg::ADDR_W-1:0]        rsp_cursor_position
);

   logic                 valid_ff;
   logic                 valid_in;
   tccw_pkg::result_type result_ff;

   // Free when empty or when the held item leaves at this edge.
   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_cell_write      = result_ff.cell_write;
   assign rsp_cell_address    = result_ff.cell_address;
   assign rsp_cell_value      = result_ff.cell_value;
   assign rsp_cursor_position = result_ff.cursor_position;

endmodule

`default_nettype wire

// ----- rtl/text_console_char_writer_top.sv -----
// Top level of the text console character writer.
// Instantiates tccw_in_reg, tccw_cursor and tccw_out_reg; uses tccw_pkg.
//
//   Port group  Direction  Handshake             Payload
//   req_*       in         req_valid/req_stall   req_char_code
//   rsp_*       out        rsp_valid/rsp_stall   cell_write, cell_address,
//                                                cell_value, cursor_position
//   csr_*       in         csr_write_enable      csr_write_data (attribute)
//
// One item per cycle while rsp does not stall; each accepted item is held in the input register,
// passes through the cursor update and is then held in the result register, from which it is presented.
// Synchronous reset puts the cursor at the top-left and the attribute at 0x07.
// A stall on rsp holds the result; req then stalls once the input register fills.
`default_nettype none

module text_console_char_writer_top (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [tccw_pkg::CHAR_W-1:0]  req_char_code,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_cell_write,
   output logic [tccw_pkg::ADDR_W-1:0]       rsp_cell_address,
   output logic [tccw_pkg::CELL_W-1:0]       rsp_cell_value,
   output logic [tccw_pkg::ADDR_W-1:0]       rsp_cursor_position,
   input  wire logic                         csr_write_enable,
   input  wire logic [tccw_pkg::ATTR_W-1:0]  csr_write_data
);

   logic [tccw_pkg::ATTR_W-1:0] attr_ff;
   logic                        out_free;
   logic                        advance;
   tccw_pkg::in_item_type       item;
   tccw_pkg::result_type        result;

   // Attribute register
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= tccw_pkg::ATTR_RESET;
      end else if (csr_write_enable) begin
         attr_ff <= csr_write_data;
      end
   end

   tccw_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_char_code (req_char_code),
      .req_stall     (req_stall),
      .out_free      (out_free),
      .item          (item),
      .advance       (advance)
   );

   tccw_cursor u_cursor (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .advance   (advance),
      .attribute (attr_ff),
      .result    (result)
   );

   tccw_out_reg u_out_reg (
      .clock               (clock),
      .reset               (reset),
      .load                (advance),
      .result              (result),
      .out_free            (out_free),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cell_write      (rsp_cell_write),
      .rsp_cell_address    (rsp_cell_address),
      .rsp_cell_value      (rsp_cell_value),
      .rsp_cursor_position (rsp_cursor_position)
   );

   // The cursor never leaves the screen.
   a_cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_cursor_position} <
                     (tccw_pkg::ADDR_W + 1)'(tccw_pkg::POS_LIMIT)))
      else $error("cursor position beyond the screen");

   // Written cells are on screen too.
   a_cell_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cell_write |->
         ({1'b0, rsp_cell_address} < (tccw_pkg::ADDR_W + 1)'(tccw_pkg::POS_LIMIT)))
      else $error("cell address beyond the screen");

   // An item without a cell write carries zero address and value.
   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_cell_write |-> (rsp_cell_address == '0) && (rsp_cell_value == '0))
      else $error("address or value set without a cell write");

   // Both registers come out of reset empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
